// ----- sv/sfr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants for the stream find-and-replace block.
// ----------------------------------------------------------------------------
package sfr_pkg;

    // Longest pattern and replacement held by the block
    localparam int MAX_PATTERN     = 8;
    localparam int MAX_REPLACEMENT = 8;

    // One item never produces more results than this
    localparam int QUEUE_DEPTH = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN
                                                                  : MAX_REPLACEMENT;

    // Window fill count stays below the pattern length
    localparam int WCNT_W    = $clog2(MAX_PATTERN);
    localparam int QCNT_W    = $clog2(QUEUE_DEPTH + 1);
    localparam int LEN_W     = 4;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_BYTES      = 2'd0,
        CFG_PATTERN_LENGTH     = 2'd1,
        CFG_REPLACEMENT_BYTES  = 2'd2,
        CFG_REPLACEMENT_LENGTH = 2'd3
    } t_cfg_idx;

    // Source of the results loaded for one item
    typedef enum logic [1:0] {
        SRC_WIN  = 2'd0,
        SRC_REP  = 2'd1,
        SRC_MARK = 2'd2
    } t_seq_src;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_has_byte;
        logic       out_last;
    } t_out_item;

    // Window cell control
    typedef struct packed {
        logic sel_in;   // this cell is the write position for the new byte
        logic load;     // store the new byte
        logic shift;    // take the neighbor's byte
    } t_win_ctl;

    // Result queue entry and control
    typedef struct packed {
        logic [7:0] data;
        logic       has;
    } t_qent;

    typedef struct packed {
        logic load;
        logic pop;
    } t_q_ctl;

endpackage

// ----- sv/sfr_win_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_win_cell
// One byte of the match window: holds a byte, compares it with its pattern
// byte and hands it to the next-older cell on a shift.
// ----------------------------------------------------------------------------
module sfr_win_cell import sfr_pkg::*; (
    input  logic       i_clk,
    input  t_win_ctl   i_ctl,
    input  logic [7:0] i_byte,
    input  logic [7:0] i_next_view,
    input  logic [7:0] i_pat_byte,
    output logic [7:0] o_view,
    output logic       o_eq
);

    logic [7:0] r_byte;
    logic [7:0] n_byte;

    // Window content as seen with the new byte written in place
    assign o_view = i_ctl.sel_in ? i_byte : r_byte;
    assign o_eq   = (o_view == i_pat_byte);

    always_comb begin
        n_byte = r_byte;
        if (i_ctl.shift) begin
            n_byte = i_next_view;
        end else if (i_ctl.load) begin
            n_byte = i_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
    end

endmodule

// ----- sv/sfr_out_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_out_cell
// One entry of the result queue: loaded in parallel, shifts toward the
// output on each pop.
// ----------------------------------------------------------------------------
module sfr_out_cell import sfr_pkg::*; (
    input  logic   i_clk,
    input  t_q_ctl i_ctl,
    input  t_qent  i_load_ent,
    input  t_qent  i_next_ent,
    output t_qent  o_ent
);

    t_qent r_ent;
    t_qent n_ent;

    always_comb begin
        n_ent = r_ent;
        if (i_ctl.load) begin
            n_ent = i_load_ent;
        end else if (i_ctl.pop) begin
            n_ent = i_next_ent;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
    end

    assign o_ent = r_ent;

endmodule

// ----- sv/stream_find_replace_top.sv -----
`timescale 1ns / 1ps
// Path: an item's first result goes through the result queue, then the output register.
// Throughput: one item per cycle while each item yields at most one result and the
//   output is not stalled; an item yielding several results (replacement or end-of-string
//   flush) holds the input until the result queue has drained into the output register.
// Reset (synchronous, active low) clears the configuration registers, the window
//   fill count, the result queue count and the output valid.
// ----------------------------------------------------------------------------
// stream_find_replace_top
// Streaming find-and-replace-all: a row of window cells finds the pattern,
// a row of queue cells serializes the results.
// ----------------------------------------------------------------------------
module stream_find_replace_top import sfr_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_item,
    // output channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_item,
    // configuration
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    // Configuration registers
    logic [8*MAX_PATTERN-1:0]     r_pat;
    logic [LEN_W-1:0]             r_plen;
    logic [8*MAX_REPLACEMENT-1:0] r_rep;
    logic [LEN_W-1:0]             r_rlen;

    // Window and queue control state
    logic [WCNT_W-1:0] r_cnt;
    logic [WCNT_W-1:0] n_cnt;
    logic [QCNT_W-1:0] r_qn;
    logic [QCNT_W-1:0] n_qn;
    logic              r_qlast;
    logic              r_ov;
    t_out_item         r_out;

    logic [LEN_W-1:0]  plen_c;
    logic [LEN_W-1:0]  rlen_c;
    logic [LEN_W-1:0]  cnt_inc;
    logic              in_acc;
    logic              q_pop;
    logic              pass;
    logic              full;
    logic              match;
    logic              hit;
    logic              shift_mode;
    logic              keep_mode;
    logic              last;
    t_seq_src          src;
    logic [QCNT_W-1:0] seq_len;

    logic [7:0]        view [MAX_PATTERN];
    logic              eq   [MAX_PATTERN];
    t_qent             qent [QUEUE_DEPTH];
    t_q_ctl            q_ctl;

    // Clamp lengths to what the cells hold
    assign plen_c = (r_plen > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : r_plen;
    assign rlen_c = (r_rlen > LEN_W'(MAX_REPLACEMENT)) ? LEN_W'(MAX_REPLACEMENT) : r_rlen;

    // Handshakes: take an item once the queue is empty or drains its last entry now
    assign q_pop      = (r_qn != '0) && (!r_ov || !i_out_stall);
    assign o_in_stall = !((r_qn == '0) || ((r_qn == QCNT_W'(1)) && q_pop));
    assign in_acc     = i_in_valid && !o_in_stall;
    assign last       = i_in_item.in_last;

    // Window decision
    assign cnt_inc = LEN_W'(r_cnt) + LEN_W'(1);
    assign pass    = (plen_c == '0);
    assign full    = (cnt_inc >= plen_c);

    always_comb begin
        match = 1'b1;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            if ((LEN_W'(i) < plen_c) && !eq[i]) begin
                match = 1'b0;
            end
        end
    end

    assign hit        = !pass && full && match;
    assign shift_mode = !pass && full && !match && !last;
    assign keep_mode  = !pass && !full && !last;

    // Results caused by this item
    always_comb begin
        src     = SRC_WIN;
        seq_len = '0;
        if (pass) begin
            seq_len = QCNT_W'(cnt_inc);
        end else if (hit) begin
            src     = SRC_REP;
            seq_len = QCNT_W'(rlen_c);
        end else if (full) begin
            seq_len = last ? QCNT_W'(cnt_inc) : QCNT_W'(1);
        end else begin
            seq_len = last ? QCNT_W'(cnt_inc) : QCNT_W'(0);
        end
        // empty end marker
        if (last && (seq_len == '0)) begin
            src     = SRC_MARK;
            seq_len = QCNT_W'(1);
        end
    end

    // Window cell row
    for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_win
        t_win_ctl   ctl;
        logic [7:0] next_view;

        assign ctl.sel_in = (r_cnt == WCNT_W'(i));
        assign ctl.load   = in_acc && keep_mode && ctl.sel_in;
        assign ctl.shift  = in_acc && shift_mode;

        if (i < MAX_PATTERN - 1) begin : g_mid
            assign next_view = view[i+1];
        end else begin : g_end
            assign next_view = 8'h00;
        end

        sfr_win_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (ctl),
            .i_byte      (i_in_item.in_byte),
            .i_next_view (next_view),
            .i_pat_byte  (r_pat[8*i +: 8]),
            .o_view      (view[i]),
            .o_eq        (eq[i])
        );
    end

    // Result queue cell row
    assign q_ctl.load = in_acc;
    assign q_ctl.pop  = q_pop;

    for (genvar j = 0; j < QUEUE_DEPTH; j++) begin : g_q
        t_qent load_ent;
        t_qent next_ent;

        always_comb begin
            load_ent = '{data: 8'h00, has: 1'b1};
            case (src)
                SRC_REP: begin
                    if (j < MAX_REPLACEMENT) begin
                        load_ent.data = r_rep[8*j +: 8];
                    end
                end
                SRC_WIN: begin
                    if (j < MAX_PATTERN) begin
                        load_ent.data = view[j];
                    end
                end
                SRC_MARK: begin
                    load_ent.has = 1'b0;
                end
                default: begin
                    load_ent.has = 1'b0;
                end
            endcase
        end

        if (j < QUEUE_DEPTH - 1) begin : g_mid
            assign next_ent = qent[j+1];
        end else begin : g_end
            assign next_ent = '{data: 8'h00, has: 1'b0};
        end

        sfr_out_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (q_ctl),
            .i_load_ent (load_ent),
            .i_next_ent (next_ent),
            .o_ent      (qent[j])
        );
    end

    // Next window count and queue count
    always_comb begin
        n_cnt = r_cnt;
        if (in_acc) begin
            if (shift_mode) begin
                n_cnt = r_cnt;
            end else if (keep_mode) begin
                n_cnt = r_cnt + WCNT_W'(1);
            end else begin
                n_cnt = '0;
            end
        end
        if (i_cfg_we && ((t_cfg_idx'(i_cfg_idx) == CFG_PATTERN_BYTES) ||
                         (t_cfg_idx'(i_cfg_idx) == CFG_PATTERN_LENGTH))) begin
            n_cnt = '0;
        end
    end

    always_comb begin
        n_qn = r_qn;
        if (in_acc) begin
            n_qn = seq_len;
        end else if (q_pop) begin
            n_qn = r_qn - QCNT_W'(1);
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_qn    <= '0;
            r_qlast <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            r_qn  <= n_qn;
            if (in_acc) begin
                r_qlast <= last;
            end
            if (q_pop) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat  <= '0;
            r_plen <= '0;
            r_rep  <= '0;
            r_rlen <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_PATTERN_BYTES:      r_pat  <= i_cfg_data[8*MAX_PATTERN-1:0];
                CFG_PATTERN_LENGTH:     r_plen <= i_cfg_data[LEN_W-1:0];
                CFG_REPLACEMENT_BYTES:  r_rep  <= i_cfg_data[8*MAX_REPLACEMENT-1:0];
                CFG_REPLACEMENT_LENGTH: r_rlen <= i_cfg_data[LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (q_pop) begin
            r_out.out_byte     <= qent[0].data;
            r_out.out_has_byte <= qent[0].has;
            r_out.out_last     <= r_qlast && (r_qn == QCNT_W'(1));
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_item  = r_out;

endmodule

// ----- bench/stream_find_replace_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stream_find_replace_top_tb
// Self-checking bench for the streaming find-and-replace block. A directed
// table covers pass-through, replacement, deletion, clamped lengths, a
// window discarded by a pattern write mid-string and the empty end marker.
// Random phases follow, each with its own configuration. Every result is
// compared in order against its typed-in value or a behavioral predictor.
// ----------------------------------------------------------------------------
module stream_find_replace_top_tb;
    import sfr_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_BYTES  = 200;

    typedef enum bit {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind        kind;
        t_cfg_idx         idx;
        logic [CFG_W-1:0] data;
        t_in_item         item;
        bit               typed;
        t_out_item        want;
    } t_row;

    // DUT connections
    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    t_in_item             i_in_item;
    logic                 o_out_valid;
    logic                 i_out_stall;
    t_out_item            o_out_item;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    // Predictor copy of configuration and window
    logic [63:0] cfg_pattern;
    logic [3:0]  cfg_pattern_len;
    logic [63:0] cfg_replace;
    logic [3:0]  cfg_replace_len;
    logic [7:0]  win_bytes [8];
    int          win_fill;

    t_out_item   due_results [$];
    t_row        dir_rows [$];
    t_out_item   oldest_due;
    bit          cur_typed;
    t_out_item   cur_want;
    int          mismatch_cnt;
    int          bytes_sent;
    int          idle_pct;

    stream_find_replace_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        #(2_000_000);
        $display("Mismatches found");
        $finish;
    end

    function automatic t_out_item make_result(logic [7:0] b, logic has);
        t_out_item r;
        r.out_byte     = b;
        r.out_has_byte = has;
        r.out_last     = 1'b0;
        return r;
    endfunction

    function automatic int clamp8(logic [3:0] len);
        return (len > 4'd8) ? 8 : int'(len);
    endfunction

    // One byte through the find-and-replace window; results queued when record is set
    function automatic void replace_step(t_in_item it, bit record);
        t_out_item res [$];
        int        plen;
        int        rlen;
        int        cnt;
        bit        hit;
        plen = clamp8(cfg_pattern_len);
        rlen = clamp8(cfg_replace_len);
        cnt  = (win_fill > 7) ? 7 : win_fill;
        if (plen == 0) begin
            for (int i = 0; i < cnt; i++) res.push_back(make_result(win_bytes[i], 1'b1));
            cnt = 0;
            res.push_back(make_result(it.in_byte, 1'b1));
        end else begin
            win_bytes[cnt] = it.in_byte;
            cnt++;
            if (cnt >= plen) begin
                hit = 1'b1;
                for (int i = 0; i < plen; i++) begin
                    if (win_bytes[i] != cfg_pattern[8*i +: 8]) hit = 1'b0;
                end
                if (hit) begin
                    for (int i = 0; i < rlen; i++)
                        res.push_back(make_result(cfg_replace[8*i +: 8], 1'b1));
                    cnt = 0;
                end else begin
                    res.push_back(make_result(win_bytes[0], 1'b1));
                    for (int i = 1; i < cnt; i++) win_bytes[i-1] = win_bytes[i];
                    cnt--;
                end
            end
            if (it.in_last) begin
                for (int i = 0; i < cnt; i++) res.push_back(make_result(win_bytes[i], 1'b1));
                cnt = 0;
            end
        end
        win_fill = cnt;
        if (it.in_last) begin
            // nothing emitted on the final byte: empty end marker
            if (res.size() == 0) res.push_back(make_result(8'h00, 1'b0));
            res[res.size()-1].out_last = 1'b1;
        end
        if (record) begin
            foreach (res[i]) due_results.push_back(res[i]);
        end
    endfunction

    // Output check, then prediction for the item accepted at this edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (due_results.size() == 0) begin
                    $error("unexpected result: out_byte %02h out_has_byte %0b out_last %0b",
                           o_out_item.out_byte, o_out_item.out_has_byte,
                           o_out_item.out_last);
                    mismatch_cnt++;
                end else begin
                    oldest_due = due_results.pop_front();
                    if (o_out_item.out_byte !== oldest_due.out_byte) begin
                        $error("out_byte: expected %02h, got %02h",
                               oldest_due.out_byte, o_out_item.out_byte);
                        mismatch_cnt++;
                    end
                    if (o_out_item.out_has_byte !== oldest_due.out_has_byte) begin
                        $error("out_has_byte: expected %0b, got %0b",
                               oldest_due.out_has_byte, o_out_item.out_has_byte);
                        mismatch_cnt++;
                    end
                    if (o_out_item.out_last !== oldest_due.out_last) begin
                        $error("out_last: expected %0b, got %0b",
                               oldest_due.out_last, o_out_item.out_last);
                        mismatch_cnt++;
                    end
                end
            end
            if (i_in_valid && !o_in_stall) begin
                if (cur_typed) begin
                    replace_step(i_in_item, 1'b0);
                    due_results.push_back(cur_want);
                end else begin
                    replace_step(i_in_item, 1'b1);
                end
            end
        end
    end

    // Receiver backpressure
    always @(negedge i_clk) begin
        i_out_stall = ($urandom_range(0, 99) < idle_pct);
    end

    // Send one item; returns at the falling edge after it is accepted
    task automatic send_item(t_in_item it, bit typed, t_out_item want);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_item  = it;
        cur_typed  = typed;
        cur_want   = want;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
        i_in_valid = 1'b0;
        bytes_sent++;
    endtask

    // Register write once all results are out and the pipeline has settled
    task automatic write_reg(t_cfg_idx idx, logic [CFG_W-1:0] data);
        while (due_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        case (idx)
            CFG_PATTERN_BYTES: begin
                cfg_pattern = data;
                win_fill    = 0;
            end
            CFG_PATTERN_LENGTH: begin
                cfg_pattern_len = data[3:0];
                win_fill        = 0;
            end
            CFG_REPLACEMENT_BYTES:  cfg_replace     = data;
            CFG_REPLACEMENT_LENGTH: cfg_replace_len = data[3:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Directed table builders
    function automatic void row_cfg(t_cfg_idx idx, logic [CFG_W-1:0] data);
        t_row r;
        r.kind  = ROW_CFG;
        r.idx   = idx;
        r.data  = data;
        r.item  = '0;
        r.typed = 1'b0;
        r.want  = '0;
        dir_rows.push_back(r);
    endfunction

    function automatic void row_item(logic [7:0] b, logic last);
        t_row r;
        r.kind         = ROW_ITEM;
        r.idx          = CFG_PATTERN_BYTES;
        r.data         = '0;
        r.item.in_byte = b;
        r.item.in_last = last;
        r.typed        = 1'b0;
        r.want         = '0;
        dir_rows.push_back(r);
    endfunction

    // Item with its single result typed in
    function automatic void row_chk(logic [7:0] b, logic last,
                                    logic [7:0] ob, logic oh, logic ol);
        row_item(b, last);
        dir_rows[dir_rows.size()-1].typed = 1'b1;
        dir_rows[dir_rows.size()-1].want  = '{out_byte: ob, out_has_byte: oh, out_last: ol};
    endfunction

    function automatic void build_directed();
        // pass-through after reset, byte extremes, zero byte
        row_chk(8'h41, 1'b0, 8'h41, 1'b1, 1'b0);
        row_chk(8'hFF, 1'b0, 8'hFF, 1'b1, 1'b0);
        row_chk(8'h00, 1'b0, 8'h00, 1'b1, 1'b0);
        row_chk(8'h01, 1'b1, 8'h01, 1'b1, 1'b1);
        // "ab" -> "XYZ", leaves an 'a' held in the window
        row_cfg(CFG_PATTERN_BYTES, 64'h6261);
        row_cfg(CFG_PATTERN_LENGTH, 64'd2);
        row_cfg(CFG_REPLACEMENT_BYTES, 64'h5A5958);
        row_cfg(CFG_REPLACEMENT_LENGTH, 64'd3);
        row_item(8'h61, 1'b0);
        row_item(8'h62, 1'b0);
        row_item(8'h61, 1'b0);
        row_item(8'h61, 1'b0);
        row_item(8'h62, 1'b0);
        row_item(8'h61, 1'b0);
        // pattern write mid-string drops the held byte; match deleted at the end
        row_cfg(CFG_PATTERN_LENGTH, 64'd2);
        row_cfg(CFG_REPLACEMENT_LENGTH, 64'd0);
        row_item(8'h61, 1'b0);
        row_chk(8'h62, 1'b1, 8'h00, 1'b0, 1'b1);
        // over-range lengths clamp to eight bytes
        row_cfg(CFG_PATTERN_BYTES, 64'hFFFF_FFFF_FFFF_FFFF);
        row_cfg(CFG_PATTERN_LENGTH, 64'd15);
        row_cfg(CFG_REPLACEMENT_BYTES, 64'h0102_0304_0506_0708);
        row_cfg(CFG_REPLACEMENT_LENGTH, 64'd15);
        for (int i = 0; i < 8; i++) row_item(8'hFF, 1'b0);
        // partial pattern at the tail is flushed as plain bytes
        row_item(8'hFF, 1'b0);
        row_item(8'hFF, 1'b0);
        row_item(8'hFE, 1'b1);
    endfunction

    function automatic logic [3:0] pick_len(int zero_weight);
        int r;
        r = $urandom_range(0, 19);
        if (r < zero_weight) return 4'd0;
        if (r < zero_weight + 2) return 4'($urandom_range(9, 15));
        return 4'($urandom_range(1, 8));
    endfunction

    // One random string: mostly whole pattern copies and prefixes, some noise
    task automatic send_text(int n, bit finish, bit narrow);
        logic [7:0] txt [$];
        t_in_item   it;
        int         plen;
        int         pick;
        int         cut;
        plen = clamp8(cfg_pattern_len);
        while (txt.size() < n) begin
            pick = $urandom_range(0, 9);
            if (plen > 0 && pick < 4) begin
                for (int k = 0; k < plen; k++) txt.push_back(cfg_pattern[8*k +: 8]);
            end else if (plen > 1 && pick < 6) begin
                cut = $urandom_range(1, plen - 1);
                for (int k = 0; k < cut; k++) txt.push_back(cfg_pattern[8*k +: 8]);
            end else if (narrow) begin
                txt.push_back(8'h61 + 8'($urandom_range(0, 2)));
            end else begin
                txt.push_back(8'($urandom_range(1, 255)));
            end
        end
        foreach (txt[k]) begin
            it.in_byte = txt[k];
            it.in_last = finish && (k == txt.size() - 1);
            send_item(it, 1'b0, '0);
        end
    endtask

    // Stimulus
    initial begin
        logic [63:0] pat;
        bit          narrow;
        int          phase;
        int          nstr;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in_item    = '0;
        i_out_stall  = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = '0;
        i_cfg_data   = '0;
        cur_typed    = 1'b0;
        cur_want     = '0;
        mismatch_cnt = 0;
        bytes_sent   = 0;
        idle_pct     = 24;
        cfg_pattern     = '0;
        cfg_pattern_len = '0;
        cfg_replace     = '0;
        cfg_replace_len = '0;
        win_fill        = 0;
        foreach (win_bytes[i]) win_bytes[i] = '0;

        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        build_directed();
        foreach (dir_rows[k]) begin
            if (dir_rows[k].kind == ROW_CFG)
                write_reg(dir_rows[k].idx, dir_rows[k].data);
            else
                send_item(dir_rows[k].item, dir_rows[k].typed, dir_rows[k].want);
        end

        // Random phases, each under a fresh (partial) configuration
        bytes_sent = 0;
        phase      = 0;
        while (bytes_sent < RANDOM_BYTES) begin
            phase++;
            // a long stretch with no idling on either side
            idle_pct = (phase == 3 || phase == 4) ? 0 : 24;
            narrow   = $urandom_range(0, 1);
            if (phase == 1 || $urandom_range(0, 3) != 0) begin
                for (int i = 0; i < 8; i++)
                    pat[8*i +: 8] = narrow ? 8'h61 + 8'($urandom_range(0, 1))
                                           : 8'($urandom_range(1, 255));
                write_reg(CFG_PATTERN_BYTES, pat);
            end
            if (phase == 1 || $urandom_range(0, 3) != 0)
                write_reg(CFG_PATTERN_LENGTH, 64'(pick_len(2)));
            if (phase == 1 || $urandom_range(0, 3) != 0)
                write_reg(CFG_REPLACEMENT_BYTES, {$urandom(), $urandom()});
            if (phase == 1 || $urandom_range(0, 3) != 0)
                write_reg(CFG_REPLACEMENT_LENGTH, 64'(pick_len(4)));
            nstr = $urandom_range(1, 4);
            for (int s = 0; s < nstr; s++)
                // the last string is sometimes left open across the next write
                send_text($urandom_range(1, 16),
                          !(s == nstr - 1 && $urandom_range(0, 3) == 0), narrow);
        end

        while (due_results.size() != 0) @(negedge i_clk);
        repeat (4 * SETTLE_CYCLES) @(negedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ----- files.f -----
sv/sfr_pkg.sv
sv/sfr_win_cell.sv
sv/sfr_out_cell.sv
sv/stream_find_replace_top.sv
bench/stream_find_replace_top_tb.sv
